FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/opdru_pkg.sv
package opdru_pkg;

    localparam int COLUMNS     = 128;
    localparam int QUIET_GAP   = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam int COL_W      = $clog2(COLUMNS);
    localparam int PAGE_W     = 3;
    localparam int OFFSET_W   = 7;
    localparam int SLOTS      = QUIET_GAP + 1;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int PEND_IDX_W = (QUIET_GAP > 1) ? $clog2(QUIET_GAP) : 1;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OFFSET_W-1:0] COL_OFFSET_RESET = OFFSET_W'(2);

    localparam logic [7:0] CMD_PAGE    = 8'hB0;
    localparam logic [7:0] CMD_COL_HI  = 8'h10;
    localparam logic [7:0] MASK_LOW    = 8'h0F;
    localparam logic [7:0] MASK_HIGH   = 8'hF0;
    localparam logic [7:0] CTRL_CMD    = 8'h00;
    localparam logic [7:0] CTRL_DATA   = 8'h40;

    // The kind bit is bit 6 of the control byte that precedes the payload on the link.
    localparam logic KIND_CMD  = CTRL_CMD[6];
    localparam logic KIND_DATA = CTRL_DATA[6];

    // Everything one column item causes: an optional command transfer, then data bytes.
    typedef struct packed {
        logic                       page_en;
        logic [PAGE_W-1:0]          page;
        logic                       cmd_en;
        logic [7:0]                 addr;
        logic [CNT_W-1:0]           ndata;
        logic [SLOTS-1:0][7:0]      bytes;
        logic                       last_end;
    } t_run_rec;

    typedef struct packed {
        logic [COL_W-1:0] count;
        logic             in_run;
    } t_front_status;

    typedef enum logic [3:0] {
        PH_PAGE = 4'b0001,
        PH_HI   = 4'b0010,
        PH_LO   = 4'b0100,
        PH_DATA = 4'b1000
    } t_phase;

endpackage

FILE: rtl/opdru_front.sv
module opdru_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [opdru_pkg::PAGE_W-1:0]      i_page,
    input  logic [7:0]                        i_new_byte,
    input  logic [7:0]                        i_old_byte,
    input  logic                              i_cfg_we,
    input  logic [opdru_pkg::OFFSET_W-1:0]    i_cfg_wdata,
    output logic                              o_push,
    output opdru_pkg::t_run_rec               o_rec,
    output opdru_pkg::t_front_status          o_status
);

    localparam int G = opdru_pkg::QUIET_GAP;

    logic [opdru_pkg::OFFSET_W-1:0] r_offset;
    logic [opdru_pkg::COL_W-1:0]    r_count, n_count;
    logic [G-1:0][7:0]              r_pend_bytes, n_pend_bytes;
    logic [G-1:0]                   r_pend_eq, n_pend_eq;
    logic                           r_in_run, n_in_run;
    logic                           r_page_sent, n_page_sent;

    logic [G:0][7:0]                win_bytes;
    logic [G:0]                     win_eq;
    logic                           cur_eq;
    logic                           at_last;
    logic                           emitting;
    logic                           quiet;
    logic                           run;
    logic                           sent;
    logic                           active;
    logic                           end_flag;
    logic [opdru_pkg::COL_W-1:0]    start_col;
    opdru_pkg::t_run_rec            rec;

    always_comb begin
        cur_eq   = (i_new_byte == i_old_byte);
        at_last  = (r_count == opdru_pkg::COL_W'(opdru_pkg::COLUMNS - 1));
        emitting = (r_count >= opdru_pkg::COL_W'(G));

        win_bytes = {i_new_byte, r_pend_bytes};
        win_eq    = {cur_eq, r_pend_eq};

        // The oldest held column closes its run when every later column in the window is unchanged.
        quiet = cur_eq;
        for (int i = 1; i < G; i++) begin
            if (!r_pend_eq[i]) begin
                quiet = 1'b0;
            end
        end

        rec        = '0;
        rec.page   = i_page;
        run        = r_in_run;
        sent       = r_page_sent;
        start_col  = '0;
        active     = 1'b0;
        end_flag   = 1'b0;

        // Normally only the oldest held column is answered; the last column of a page
        // flushes the whole window, and the run is forced to end on that column.
        for (int s = 0; s <= G; s++) begin
            active = emitting && ((s == 0) || at_last);
            if (active && (run || !win_eq[s])) begin
                if (!run) begin
                    rec.cmd_en = 1'b1;
                    if (!sent) begin
                        rec.page_en = 1'b1;
                        sent        = 1'b1;
                    end
                    start_col = opdru_pkg::COL_W'(int'(r_count) - G + s);
                    rec.addr  = 8'(start_col) + 8'(r_offset);
                    run       = 1'b1;
                end
                end_flag = (s == 0) ? quiet : (s == G);
                rec.bytes[rec.ndata[opdru_pkg::SLOT_W-1:0]] = win_bytes[s];
                rec.ndata    = rec.ndata + opdru_pkg::CNT_W'(1);
                rec.last_end = end_flag;
                if (end_flag) begin
                    run = 1'b0;
                end
            end
        end

        n_pend_bytes = r_pend_bytes;
        n_pend_eq    = r_pend_eq;
        if (emitting) begin
            for (int i = 0; i + 1 < G; i++) begin
                n_pend_bytes[i] = r_pend_bytes[i + 1];
                n_pend_eq[i]    = r_pend_eq[i + 1];
            end
            n_pend_bytes[G-1] = i_new_byte;
            n_pend_eq[G-1]    = cur_eq;
        end else begin
            n_pend_bytes[r_count[opdru_pkg::PEND_IDX_W-1:0]] = i_new_byte;
            n_pend_eq[r_count[opdru_pkg::PEND_IDX_W-1:0]]    = cur_eq;
        end

        n_count     = at_last ? '0 : r_count + opdru_pkg::COL_W'(1);
        n_in_run    = at_last ? 1'b0 : run;
        n_page_sent = at_last ? 1'b0 : sent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= opdru_pkg::COL_OFFSET_RESET;
            r_count      <= '0;
            r_pend_bytes <= '0;
            r_pend_eq    <= '0;
            r_in_run     <= 1'b0;
            r_page_sent  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_count      <= n_count;
                r_pend_bytes <= n_pend_bytes;
                r_pend_eq    <= n_pend_eq;
                r_in_run     <= n_in_run;
                r_page_sent  <= n_page_sent;
            end
        end
    end

    assign o_push   = i_accept && (rec.cmd_en || (rec.ndata != '0));
    assign o_rec    = rec;
    assign o_status = {r_count, r_in_run};

endmodule

FILE: rtl/opdru_queue.sv
module opdru_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  opdru_pkg::t_run_rec  i_rec,
    input  logic                 i_pop,
    output opdru_pkg::t_run_rec  o_head,
    output logic                 o_full,
    output logic                 o_empty
);

    opdru_pkg::t_run_rec              r_mem [opdru_pkg::QUEUE_DEPTH];
    logic [opdru_pkg::QPTR_W-1:0]     r_wptr;
    logic [opdru_pkg::QPTR_W-1:0]     r_rptr;
    logic [opdru_pkg::QCNT_W-1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == opdru_pkg::QPTR_W'(opdru_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wptr + opdru_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == opdru_pkg::QPTR_W'(opdru_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rptr + opdru_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + opdru_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - opdru_pkg::QCNT_W'(1);
            end
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_full  = (r_count == opdru_pkg::QCNT_W'(opdru_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

FILE: rtl/opdru_back.sv
module opdru_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  opdru_pkg::t_run_rec  i_head,
    input  logic                 i_q_empty,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic                 o_kind,
    output logic [7:0]           o_value,
    output logic                 o_last
);

    opdru_pkg::t_phase            r_phase, n_phase, phase;
    logic                         r_fresh;
    logic [opdru_pkg::SLOT_W-1:0] r_didx;
    logic                         r_out_valid;
    logic                         r_out_kind;
    logic [7:0]                   r_out_value;
    logic                         r_out_last;

    logic                         adv;
    logic                         done;
    logic                         kind;
    logic [7:0]                   value;
    logic                         last;
    logic                         data_end;

    always_comb begin
        if (!r_fresh) begin
            phase = r_phase;
        end else if (i_head.page_en) begin
            phase = opdru_pkg::PH_PAGE;
        end else if (i_head.cmd_en) begin
            phase = opdru_pkg::PH_HI;
        end else begin
            phase = opdru_pkg::PH_DATA;
        end

        adv      = !i_q_empty && (!r_out_valid || i_pop);
        data_end = ((opdru_pkg::CNT_W'(r_didx) + opdru_pkg::CNT_W'(1)) == i_head.ndata);

        kind    = opdru_pkg::KIND_CMD;
        value   = '0;
        last    = 1'b0;
        done    = 1'b0;
        n_phase = phase;

        unique case (phase)
            opdru_pkg::PH_PAGE: begin
                value   = opdru_pkg::CMD_PAGE + 8'(i_head.page);
                n_phase = opdru_pkg::PH_HI;
            end
            opdru_pkg::PH_HI: begin
                value   = opdru_pkg::CMD_COL_HI | ((i_head.addr & opdru_pkg::MASK_HIGH) >> 4);
                n_phase = opdru_pkg::PH_LO;
            end
            opdru_pkg::PH_LO: begin
                value   = i_head.addr & opdru_pkg::MASK_LOW;
                last    = 1'b1;
                n_phase = opdru_pkg::PH_DATA;
            end
            opdru_pkg::PH_DATA: begin
                kind  = opdru_pkg::KIND_DATA;
                value = i_head.bytes[r_didx];
                last  = data_end && i_head.last_end;
                done  = data_end;
            end
            default: begin
                value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_kind  <= kind;
            r_out_value <= value;
            r_out_last  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= opdru_pkg::PH_DATA;
            r_fresh     <= 1'b1;
            r_didx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
                if (done) begin
                    r_fresh <= 1'b1;
                    r_didx  <= '0;
                end else begin
                    r_fresh <= 1'b0;
                    r_phase <= n_phase;
                    if (phase == opdru_pkg::PH_DATA) begin
                        r_didx <= r_didx + opdru_pkg::SLOT_W'(1);
                    end
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_q_pop = adv && done;
    assign o_empty = !r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_value = r_out_value;
    assign o_last  = r_out_last;

endmodule

FILE: rtl/oled_page_dirty_run_updater.sv
// Channel        Handshake              Payload
// column in      push / full            i_page, i_new_byte, i_old_byte
// panel bytes    pop / empty            o_kind, o_value, o_last_of_transfer
// offset write   i_cfg_we               i_cfg_wdata
//
// A column is taken every cycle while the four-entry record queue has room.
// Each column yields at most one record; the back end drains it one byte per cycle while pop keeps up,
// so a column costs zero to seven output bytes and the pop side sets the long-run rate.
// Reset is synchronous and clears the column count, run state and the queue.
// The output register holds the current byte; the back end loads the next one only when it is empty or popped.
`include "assert_macros.svh"

module oled_page_dirty_run_updater (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [opdru_pkg::PAGE_W-1:0]      i_page,
    input  logic [7:0]                        i_new_byte,
    input  logic [7:0]                        i_old_byte,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_kind,
    output logic [7:0]                        o_value,
    output logic                              o_last_of_transfer,
    input  logic                              i_cfg_we,
    input  logic [opdru_pkg::OFFSET_W-1:0]    i_cfg_wdata
);

    logic                         in_acc;
    logic                         rec_push;
    opdru_pkg::t_run_rec          rec;
    opdru_pkg::t_run_rec          head;
    opdru_pkg::t_front_status     status;
    logic                         q_full;
    logic                         q_empty;
    logic                         q_pop;
    logic                         page_end_acc;

    assign in_acc = push && !q_full;
    assign full   = q_full;

    assign page_end_acc = in_acc
                          && (status.count == opdru_pkg::COL_W'(opdru_pkg::COLUMNS - 1));

    opdru_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_acc),
        .i_page      (i_page),
        .i_new_byte  (i_new_byte),
        .i_old_byte  (i_old_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (rec_push),
        .o_rec       (rec),
        .o_status    (status)
    );

    opdru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (rec),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    opdru_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_kind    (o_kind),
        .o_value   (o_value),
        .o_last    (o_last_of_transfer)
    );

    `ASSERT_NEVER(a_no_push_when_full, i_clk, i_rst_n, rec_push && q_full, "push into full queue")
    `ASSERT_NEVER(a_no_pop_when_empty, i_clk, i_rst_n, q_pop && q_empty, "pop from empty queue")
    `ASSERT_CLK(a_wrap, i_clk, i_rst_n, page_end_acc |=> status.count == '0, "count did not wrap")
    `ASSERT_CLK(a_run_shut, i_clk, i_rst_n, page_end_acc |=> !status.in_run, "run left open")

endmodule
